// ----- rtl/spi3_pkg.sv -----
`timescale 1ns / 1ps

package spi3_pkg;

    // Command codes of an input item
    localparam logic [1:0] CMD_WRITE8     = 2'd0;
    localparam logic [1:0] CMD_WRITE16    = 2'd1;
    localparam logic [1:0] CMD_READ8_PFX  = 2'd2;
    localparam logic [1:0] CMD_READ8      = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_IDLES_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_ACTIVE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_BIT_ENABLE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_FROM_MISO     = 2'd3;
    localparam int CFG_DATA_W = 1;

    localparam int WORD_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int BITS_W      = 5;   // holds 0..16
    localparam int POS_W       = 4;   // bit position inside the transmit word
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BITS_W-1:0] BITS_WORD   = 5'd16;
    localparam logic [BITS_W-1:0] BITS_PREFIX = 5'd9;
    localparam logic [BITS_W-1:0] BITS_BYTE   = 5'd8;

    typedef struct packed {
        logic clock_idles_low;
        logic select_active_high;
        logic prefix_bit_enable;
        logic read_from_miso;
    } t_cfg;

    // Tick after classification by the front end
    typedef struct packed {
        logic              start;
        logic [1:0]        kind;
        logic [BITS_W-1:0] bits;
        logic [WORD_W-1:0] word;
        logic              sda_in;
        logic              miso_in;
    } t_item;

    typedef struct packed {
        logic              sck_level;
        logic              sda_out;
        logic              sda_drive;
        logic              cs_level;
        logic              busy_res;
        logic              read_done;
        logic [BYTE_W-1:0] read_byte;
    } t_result;

endpackage

// ----- rtl/spi3_if.sv -----
`timescale 1ns / 1ps

interface spi3_in_if;
    logic                          valid;
    logic                          ready;
    logic                          start_req;
    logic [1:0]                    cmd;
    logic                          dc_bit;
    logic [spi3_pkg::WORD_W-1:0]   tx_word;
    logic                          sda_in;
    logic                          miso_in;

    modport source (output valid, start_req, cmd, dc_bit, tx_word, sda_in, miso_in,
                    input ready);
    modport sink   (input valid, start_req, cmd, dc_bit, tx_word, sda_in, miso_in,
                    output ready);
endinterface

interface spi3_out_if;
    logic                          valid;
    logic                          ready;
    logic                          sck_level;
    logic                          sda_out;
    logic                          sda_drive;
    logic                          cs_level;
    logic                          busy_res;
    logic                          read_done;
    logic [spi3_pkg::BYTE_W-1:0]   read_byte;

    modport source (output valid, sck_level, sda_out, sda_drive, cs_level, busy_res,
                    read_done, read_byte, input ready);
    modport sink   (input valid, sck_level, sda_out, sda_drive, cs_level, busy_res,
                    read_done, read_byte, output ready);
endinterface

interface spi3_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [spi3_pkg::CFG_IDX_W-1:0]    index;
    logic [spi3_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/spi3_front.sv -----
`timescale 1ns / 1ps

// Decodes the command of each tick into bit count and transmit word.
module spi3_front (
    spi3_in_if.sink           i_in,
    input  spi3_pkg::t_cfg    i_cfg,
    output logic              o_push_valid,
    input  logic              i_push_ready,
    output spi3_pkg::t_item   o_push_item
);

    logic w_prefix;

    assign w_prefix = i_cfg.prefix_bit_enable
                      && (i_in.cmd == spi3_pkg::CMD_WRITE8
                          || i_in.cmd == spi3_pkg::CMD_READ8_PFX);

    assign o_push_valid = i_in.valid;
    assign i_in.ready   = i_push_ready;

    always_comb begin
        o_push_item.start   = i_in.start_req;
        o_push_item.kind    = i_in.cmd;
        o_push_item.sda_in  = i_in.sda_in;
        o_push_item.miso_in = i_in.miso_in;
        if (i_in.cmd == spi3_pkg::CMD_WRITE16) begin
            o_push_item.bits = spi3_pkg::BITS_WORD;
            o_push_item.word = i_in.tx_word;
        end else if (w_prefix) begin
            o_push_item.bits = spi3_pkg::BITS_PREFIX;
            o_push_item.word = {7'd0, i_in.dc_bit, i_in.tx_word[7:0]};
        end else begin
            o_push_item.bits = spi3_pkg::BITS_BYTE;
            o_push_item.word = {8'd0, i_in.tx_word[7:0]};
        end
    end

endmodule

// ----- rtl/spi3_queue.sv -----
`timescale 1ns / 1ps

module spi3_queue #(
    parameter int DEPTH = spi3_pkg::QUEUE_DEPTH   // 2 or more
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  spi3_pkg::t_item   i_push_item,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output spi3_pkg::t_item   o_pop_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    spi3_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push, w_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// ----- rtl/spi3_back.sv -----
`timescale 1ns / 1ps

// Bit engine: one queued tick per cycle while o_out does not stall, result held in an output register.
module spi3_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spi3_pkg::t_cfg    i_cfg,
    input  logic              i_pop_valid,
    output logic              o_pop_ready,
    input  spi3_pkg::t_item   i_pop_item,
    spi3_out_if.source        o_out
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SEND = 2'd1;
    localparam logic [1:0] PH_READ = 2'd2;

    logic [1:0]                      r_phase, n_phase;
    logic [spi3_pkg::BITS_W-1:0]     r_bits_left, n_bits_left;
    logic                            r_high_half, n_high_half;
    logic [spi3_pkg::WORD_W-1:0]     r_tx_shift, n_tx_shift;
    logic [spi3_pkg::BYTE_W-1:0]     r_rx_shift, n_rx_shift;
    logic [1:0]                      r_kind, n_kind;
    logic                            r_out_valid;
    spi3_pkg::t_result               r_out, n_out;

    logic                            w_pop;
    logic                            w_last;
    logic [spi3_pkg::POS_W-1:0]      w_pos;
    logic                            w_idle_lvl;
    logic                            w_cs_on;

    assign o_pop_ready = !r_out_valid || o_out.ready;
    assign w_pop       = i_pop_valid && o_pop_ready;
    assign w_idle_lvl  = !i_cfg.clock_idles_low;
    assign w_cs_on     = i_cfg.select_active_high;

    always_comb begin
        n_phase     = r_phase;
        n_bits_left = r_bits_left;
        n_high_half = r_high_half;
        n_tx_shift  = r_tx_shift;
        n_rx_shift  = r_rx_shift;
        n_kind      = r_kind;

        // a start request only counts while idle
        if (r_phase == PH_IDLE && i_pop_item.start) begin
            n_kind      = i_pop_item.kind;
            n_tx_shift  = i_pop_item.word;
            n_bits_left = i_pop_item.bits;
            n_rx_shift  = '0;
            n_high_half = 1'b0;
            n_phase     = PH_SEND;
        end

        w_last = (n_bits_left <= spi3_pkg::BITS_W'(1));
        w_pos  = (n_bits_left != '0) ? spi3_pkg::POS_W'(n_bits_left - 1'b1) : '0;

        n_out.sck_level = w_idle_lvl;
        n_out.sda_out   = 1'b0;
        n_out.sda_drive = 1'b1;
        n_out.cs_level  = !w_cs_on;
        n_out.busy_res  = 1'b0;
        n_out.read_done = 1'b0;
        n_out.read_byte = '0;

        case (n_phase)
            PH_SEND: begin
                n_out.busy_res = 1'b1;
                n_out.cs_level = w_cs_on;
                n_out.sda_out  = n_tx_shift[w_pos];
                if (!n_high_half) begin
                    n_high_half = 1'b1;
                end else begin
                    n_out.sck_level = !w_idle_lvl;
                    n_high_half     = 1'b0;
                    n_bits_left     = w_last ? '0 : n_bits_left - 1'b1;
                    if (w_last) begin
                        if (n_kind[1]) begin
                            n_phase     = PH_READ;
                            n_bits_left = spi3_pkg::BITS_BYTE;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
            end
            PH_READ: begin
                n_out.busy_res  = 1'b1;
                n_out.cs_level  = w_cs_on;
                n_out.sda_drive = i_cfg.read_from_miso;
                if (!n_high_half) begin
                    // sample before the pulse
                    n_rx_shift  = {n_rx_shift[spi3_pkg::BYTE_W-2:0],
                                   i_cfg.read_from_miso ? i_pop_item.miso_in
                                                        : i_pop_item.sda_in};
                    n_high_half = 1'b1;
                end else begin
                    n_out.sck_level = !w_idle_lvl;
                    n_high_half     = 1'b0;
                    n_bits_left     = w_last ? '0 : n_bits_left - 1'b1;
                    if (w_last) begin
                        n_out.read_done = 1'b1;
                        n_out.read_byte = n_rx_shift;
                        n_phase         = PH_IDLE;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bits_left <= '0;
            r_high_half <= 1'b0;
            r_kind      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_phase     <= n_phase;
                r_bits_left <= n_bits_left;
                r_high_half <= n_high_half;
                r_kind      <= n_kind;
            end
            if (w_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_tx_shift <= n_tx_shift;
            r_rx_shift <= n_rx_shift;
            r_out      <= n_out;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.sck_level = r_out.sck_level;
    assign o_out.sda_out   = r_out.sda_out;
    assign o_out.sda_drive = r_out.sda_drive;
    assign o_out.cs_level  = r_out.cs_level;
    assign o_out.busy_res  = r_out.busy_res;
    assign o_out.read_done = r_out.read_done;
    assign o_out.read_byte = r_out.read_byte;

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.read_done |-> r_out.busy_res)
        else $error("read_done without busy");

    a_read_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_READ |-> r_kind[1])
        else $error("read phase entered by a write transfer");

    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits_left <= spi3_pkg::BITS_WORD)
        else $error("bit count out of range");

    a_half_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && r_phase != PH_IDLE |=> r_high_half != $past(r_high_half))
        else $error("clock half did not advance in a busy tick");

endmodule

// ----- rtl/spi_3wire_9bit_master.sv -----
`timescale 1ns / 1ps

// Three-wire SPI master for panel setup, one half-bit tick per transfer on i_in.
// Each tick on i_in gives exactly one result on o_out with the pin levels for
// that tick (SCK, SDA, SDA enable, CS), busy, and the read byte with read_done.
// A tick with start_req while idle begins a write8 / write16 / read8 transfer;
// every serial bit takes two ticks, idle half then pulse half, MSB first.
// i_cfg writes one of four 1-bit registers (index 0..3: clock idles low,
// select active high, prefix bit enable, read from MISO); always ready.
// Path: a tick taken on i_in is written into the queue, then popped into the bit
// engine, whose output register holds its result on o_out; a stall on o_out can
// keep a tick waiting in the queue.
// Throughput: one tick per cycle while o_out does not stall, set by the bit engine,
// which takes a new tick whenever its output register is empty or being read; the
// queue and the output register keep that rate while each side stalls on its own.
// Reset: transfer state returns to idle and the registers to clock idles low,
// CS active low, prefix enabled, read from the shared SDA line.
// When o_out stalls the result holds; the queue fills and then i_in.ready drops.
module spi_3wire_9bit_master #(
    parameter int QUEUE_DEPTH = spi3_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    spi3_in_if.sink      i_in,
    spi3_cfg_if.sink     i_cfg,
    spi3_out_if.source   o_out
);

    spi3_pkg::t_cfg  r_cfg;
    logic            w_push_valid, w_push_ready;
    spi3_pkg::t_item w_push_item;
    logic            w_pop_valid, w_pop_ready;
    spi3_pkg::t_item w_pop_item;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clock_idles_low    <= 1'b1;
            r_cfg.select_active_high <= 1'b0;
            r_cfg.prefix_bit_enable  <= 1'b1;
            r_cfg.read_from_miso     <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                spi3_pkg::CFG_CLOCK_IDLES_LOW:    r_cfg.clock_idles_low    <= i_cfg.data[0];
                spi3_pkg::CFG_SELECT_ACTIVE_HIGH: r_cfg.select_active_high <= i_cfg.data[0];
                spi3_pkg::CFG_PREFIX_BIT_ENABLE:  r_cfg.prefix_bit_enable  <= i_cfg.data[0];
                spi3_pkg::CFG_READ_FROM_MISO:     r_cfg.read_from_miso     <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    spi3_front u_front (
        .i_in         (i_in),
        .i_cfg        (r_cfg),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_item  (w_push_item)
    );

    spi3_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_item  (w_push_item),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_item   (w_pop_item)
    );

    spi3_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_item  (w_pop_item),
        .o_out       (o_out)
    );

endmodule
